// ----- design/cbtp_pkg.sv -----
// ----------------------------------------------------------------------------
// cbtp_pkg
// Shared types, constants and colour tables for the colour bar test pattern.
// ----------------------------------------------------------------------------
package cbtp_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int MIN_WIDTH  = 16;
    localparam int MIN_HEIGHT = 2;

    localparam int CFG_W   = 13;
    localparam int FRAME_W = 32;
    localparam int COORD_W = 12;
    localparam int PIX_W   = 32;
    localparam int IDX_W   = 2;

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int XW = COORD_W + 1;

    // remainder of frame*6 by the box modulus, a few dividend bits per stage
    localparam int DIV_W      = FRAME_W + 3;
    localparam int REM_STEPS  = 5;
    localparam int REM_STAGES = (DIV_W + REM_STEPS - 1) / REM_STEPS;
    localparam int DIVP_W     = REM_STAGES * REM_STEPS;

    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [IDX_W-1:0] REG_PIXEL_FORMAT = 2'd2;

    localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 13'd640;
    localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 13'd480;

    localparam logic FMT_NV12   = 1'b0;
    localparam logic FMT_RGB32  = 1'b1;
    localparam logic ACT_PIXEL  = 1'b0;
    localparam logic ACT_CHROMA = 1'b1;

    localparam logic [PIX_W-1:0] RGB_DARK = 32'hFF22_2222;
    localparam logic [PIX_W-1:0] RGB_BOX  = 32'hFFFF_3333;
    localparam logic [7:0] Y_DARK    = 8'd40;
    localparam logic [7:0] Y_BOX     = 8'd220;
    localparam logic [7:0] C_NEUTRAL = 8'd128;
    localparam logic [7:0] V_BOX     = 8'd240;

    localparam logic [PIX_W-1:0] RGB_BAR [0:7] = '{
        32'hFFFF_FFFF, 32'hFFFF_FF00, 32'hFF00_FFFF, 32'hFF00_FF00,
        32'hFFFF_00FF, 32'hFFFF_0000, 32'hFF00_00FF, 32'hFF00_0000
    };
    localparam logic [7:0] Y_BAR [0:7] = '{
        8'd235, 8'd210, 8'd170, 8'd145, 8'd106, 8'd81, 8'd41, 8'd16
    };
    localparam logic [7:0] U_BAR [0:7] = '{
        8'd128, 8'd16, 8'd166, 8'd54, 8'd202, 8'd90, 8'd240, 8'd128
    };
    localparam logic [7:0] V_BAR [0:7] = '{
        8'd128, 8'd146, 8'd16, 8'd34, 8'd222, 8'd240, 8'd110, 8'd128
    };

    typedef enum logic [1:0] {
        MODE_RGB,
        MODE_LUMA,
        MODE_CHROMA
    } mode_t;

    typedef struct packed {
        logic [WW-1:0]       w;
        logic [WW-1:0]       w_half;
        logic [HW-1:0]       h;
        logic [HW-1:0]       h_half;
        logic [HW-1:0]       top;
        logic [HW-1:0]       ctop;
        logic [7:1][WW-1:0]  bar_edge;
        logic [WW-1:0]       box_w;
        logic [WW-1:0]       box_mod;
    } geom_t;

    typedef struct packed {
        mode_t               mode;
        logic                outside;
        logic                in_bars;
        logic [2:0]          bar;
        logic [XW-1:0]       x;
        logic [WW-1:0]       rem;
        logic [DIVP_W-1:0]   dvd;
    } item_t;

    function automatic geom_t cbtp_geom(input logic [CFG_W-1:0] raw_w,
                                        input logic [CFG_W-1:0] raw_h);
        geom_t         g;
        logic [WW-1:0] w;
        logic [HW-1:0] h;
        logic [HW+1:0] h3;
        logic [WW-1:0] bw;
        if (32'(raw_w) < 32'(MIN_WIDTH)) begin
            w = WW'(MIN_WIDTH);
        end else if (32'(raw_w) > 32'(MAX_WIDTH)) begin
            w = WW'(MAX_WIDTH);
        end else begin
            w = WW'(raw_w);
        end
        if (32'(raw_h) < 32'(MIN_HEIGHT)) begin
            h = HW'(MIN_HEIGHT);
        end else if (32'(raw_h) > 32'(MAX_HEIGHT)) begin
            h = HW'(MAX_HEIGHT);
        end else begin
            h = HW'(raw_h);
        end
        h3 = (HW+2)'(h) + ((HW+2)'(h) << 1);
        bw = w >> 3;
        g.w      = w;
        g.w_half = w >> 1;
        g.h      = h;
        g.h_half = h >> 1;
        g.top    = HW'(h3 >> 2);
        g.ctop   = g.top >> 1;
        for (int k = 1; k <= 7; k++) begin
            g.bar_edge[k] = WW'(32'(bw) * k);
        end
        g.box_w   = w >> 4;
        g.box_mod = w - (w >> 4);
        return g;
    endfunction

endpackage

// ----- design/cbtp_cfg.sv -----
// ----------------------------------------------------------------------------
// cbtp_cfg
// Configuration registers and the frame geometry derived from them.
// ----------------------------------------------------------------------------
module cbtp_cfg (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [cbtp_pkg::IDX_W-1:0]  cfg_index,
    input  logic [cbtp_pkg::CFG_W-1:0]  cfg_data,
    output cbtp_pkg::geom_t             geom,
    output logic                        fmt
);
    import cbtp_pkg::*;

    logic [CFG_W-1:0] width_reg, width_next;
    logic [CFG_W-1:0] height_reg, height_next;
    logic             fmt_reg, fmt_next;
    geom_t            geom_reg;

    assign cfg_ready = 1'b1;

    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        fmt_next    = fmt_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_FRAME_WIDTH:  width_next  = cfg_data;
                REG_FRAME_HEIGHT: height_next = cfg_data;
                REG_PIXEL_FORMAT: fmt_next    = cfg_data[0];
                default: ;
            endcase
        end
    end

    // geometry registered alongside the raw values, so it is ready at once
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= RST_FRAME_WIDTH;
            height_reg <= RST_FRAME_HEIGHT;
            fmt_reg    <= FMT_NV12;
            geom_reg   <= cbtp_geom(RST_FRAME_WIDTH, RST_FRAME_HEIGHT);
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
            fmt_reg    <= fmt_next;
            geom_reg   <= cbtp_geom(width_next, height_next);
        end
    end

    assign geom = geom_reg;
    assign fmt  = fmt_reg;

endmodule

// ----- design/cbtp_front.sv -----
// ----------------------------------------------------------------------------
// cbtp_front
// First stage: plane decode, frame bounds, band split, bar index, frame*6.
// ----------------------------------------------------------------------------
module cbtp_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  cbtp_pkg::geom_t               geom,
    input  logic                          fmt,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          action,
    input  logic [cbtp_pkg::FRAME_W-1:0]  frame_number,
    input  logic [cbtp_pkg::COORD_W-1:0]  line,
    input  logic [cbtp_pkg::COORD_W-1:0]  column,
    output logic                          out_valid,
    input  logic                          out_ready,
    output cbtp_pkg::item_t               out_item
);
    import cbtp_pkg::*;

    logic  valid_reg;
    item_t item_reg, item_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        logic chroma;
        chroma = (fmt == FMT_NV12) && (action == ACT_CHROMA);
        item_next = '0;
        if (fmt == FMT_RGB32) begin
            item_next.mode = MODE_RGB;
        end else if (chroma) begin
            item_next.mode = MODE_CHROMA;
        end else begin
            item_next.mode = MODE_LUMA;
        end
        if (chroma) begin
            item_next.x       = {column, 1'b0};
            item_next.outside = (32'(line) >= 32'(geom.h_half)) ||
                                (32'(column) >= 32'(geom.w_half));
            item_next.in_bars = 32'(line) < 32'(geom.ctop);
        end else begin
            item_next.x       = {1'b0, column};
            item_next.outside = (32'(line) >= 32'(geom.h)) ||
                                (32'(column) >= 32'(geom.w));
            item_next.in_bars = 32'(line) < 32'(geom.top);
        end
        // edges rise with k, so the last one passed is the bar
        for (int k = 1; k <= 7; k++) begin
            if (32'(item_next.x) >= 32'(geom.bar_edge[k])) begin
                item_next.bar = 3'(k);
            end
        end
        item_next.dvd = (DIVP_W'(frame_number) << 2) + (DIVP_W'(frame_number) << 1);
        item_next.rem = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// ----- design/cbtp_mod_stage.sv -----
// ----------------------------------------------------------------------------
// cbtp_mod_stage
// One slice of the box position remainder: a few restoring steps per stage.
// ----------------------------------------------------------------------------
module cbtp_mod_stage (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cbtp_pkg::geom_t      geom,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  cbtp_pkg::item_t      in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output cbtp_pkg::item_t      out_item
);
    import cbtp_pkg::*;

    logic  valid_reg;
    item_t item_reg, item_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        logic [WW:0]       t;
        logic [WW-1:0]     r;
        logic [DIVP_W-1:0] d;
        r = in_item.rem;
        d = in_item.dvd;
        t = '0;
        for (int i = 0; i < REM_STEPS; i++) begin
            t = {r, d[DIVP_W-1]};
            d = d << 1;
            if (t >= {1'b0, geom.box_mod}) begin
                t = t - {1'b0, geom.box_mod};
            end
            r = t[WW-1:0];
        end
        item_next     = in_item;
        item_next.rem = r;
        item_next.dvd = d;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    // partial remainder never reaches the modulus
    a_rem_range: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (item_reg.rem < geom.box_mod))
        else $error("partial remainder out of range");

endmodule

// ----- design/cbtp_back.sv -----
// ----------------------------------------------------------------------------
// cbtp_back
// Last stage: box test, colour lookup and the result register.
// ----------------------------------------------------------------------------
module cbtp_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  cbtp_pkg::geom_t             geom,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  cbtp_pkg::item_t             in_item,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [cbtp_pkg::PIX_W-1:0]  pixel_value,
    output logic                        out_of_frame
);
    import cbtp_pkg::*;

    logic             valid_reg;
    logic [PIX_W-1:0] pixel_reg, pixel_next;
    logic             outside_reg;
    mode_t            mode_reg;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        logic box;
        box = (32'(in_item.x) >= 32'(in_item.rem)) &&
              (32'(in_item.x) < (32'(in_item.rem) + 32'(geom.box_w)));
        pixel_next = '0;
        if (!in_item.outside) begin
            case (in_item.mode)
                MODE_RGB: begin
                    if (in_item.in_bars) begin
                        pixel_next = RGB_BAR[in_item.bar];
                    end else begin
                        pixel_next = box ? RGB_BOX : RGB_DARK;
                    end
                end
                MODE_LUMA: begin
                    if (in_item.in_bars) begin
                        pixel_next = PIX_W'(Y_BAR[in_item.bar]);
                    end else begin
                        pixel_next = PIX_W'(box ? Y_BOX : Y_DARK);
                    end
                end
                MODE_CHROMA: begin
                    if (in_item.in_bars) begin
                        pixel_next = PIX_W'({V_BAR[in_item.bar], U_BAR[in_item.bar]});
                    end else begin
                        pixel_next = PIX_W'({box ? V_BOX : C_NEUTRAL, C_NEUTRAL});
                    end
                end
                default: pixel_next = '0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            pixel_reg   <= pixel_next;
            outside_reg <= in_item.outside;
            mode_reg    <= in_item.mode;
        end
    end

    assign out_valid    = valid_reg;
    assign pixel_value  = pixel_reg;
    assign out_of_frame = outside_reg;

    a_outside_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && outside_reg) |-> (pixel_reg == '0))
        else $error("out of frame beat carries data");

    a_luma_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && mode_reg == MODE_LUMA) |-> (pixel_reg[PIX_W-1:8] == '0))
        else $error("luma beat wider than a byte");

    a_chroma_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && mode_reg == MODE_CHROMA) |-> (pixel_reg[PIX_W-1:16] == '0))
        else $error("chroma beat wider than a pair");

    a_rgb_alpha: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && mode_reg == MODE_RGB && !outside_reg) |->
        (pixel_reg[PIX_W-1:PIX_W-8] == 8'hFF))
        else $error("ARGB word not opaque");

endmodule

// ----- design/color_bar_test_pattern_pixel.sv -----
// ----------------------------------------------------------------------------
// color_bar_test_pattern_pixel
// Colour bar test frame, one pixel per beat, RGB32 or NV12.
// ----------------------------------------------------------------------------
// Usage
//   s_* beat: action, frame_number, line, column. m_* beat: pixel_value and
//   out_of_frame. cfg_* writes frame_width (0), frame_height (1) and
//   pixel_format (2); cfg_ready is always high, writes take effect on the
//   next cycle and belong only while the pipeline is empty.
//   An s_ beat passes one decode stage, seven remainder stages for the box
//   position (five dividend bits each) and one colour stage holding the
//   result register. Throughput is one pixel per cycle while m_ready is
//   high; every stage has its own valid bit.
//   When the receiver stalls, the stages behind the result fill their empty
//   slots first, and s_ready drops only once all of them hold beats.
//   Synchronous active-low reset empties the pipeline and loads the
//   registers with 640 x 480, NV12. No memory, so no clearing pass.
// ----------------------------------------------------------------------------
module color_bar_test_pattern_pixel (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cbtp_pkg::IDX_W-1:0]    cfg_index,
    input  logic [cbtp_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_action,
    input  logic [cbtp_pkg::FRAME_W-1:0]  s_frame_number,
    input  logic [cbtp_pkg::COORD_W-1:0]  s_line,
    input  logic [cbtp_pkg::COORD_W-1:0]  s_column,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [cbtp_pkg::PIX_W-1:0]    m_pixel_value,
    output logic                          m_out_of_frame
);
    import cbtp_pkg::*;

    geom_t                 geom;
    logic                  fmt;
    logic [REM_STAGES:0]   stg_valid;
    logic [REM_STAGES:0]   stg_ready;
    item_t                 stg_item [REM_STAGES+1];

    cbtp_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .geom      (geom),
        .fmt       (fmt)
    );

    cbtp_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .geom         (geom),
        .fmt          (fmt),
        .in_valid     (s_valid),
        .in_ready     (s_ready),
        .action       (s_action),
        .frame_number (s_frame_number),
        .line         (s_line),
        .column       (s_column),
        .out_valid    (stg_valid[0]),
        .out_ready    (stg_ready[0]),
        .out_item     (stg_item[0])
    );

    for (genvar g = 0; g < REM_STAGES; g++) begin : g_rem
        cbtp_mod_stage u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .geom      (geom),
            .in_valid  (stg_valid[g]),
            .in_ready  (stg_ready[g]),
            .in_item   (stg_item[g]),
            .out_valid (stg_valid[g+1]),
            .out_ready (stg_ready[g+1]),
            .out_item  (stg_item[g+1])
        );
    end

    cbtp_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .geom         (geom),
        .in_valid     (stg_valid[REM_STAGES]),
        .in_ready     (stg_ready[REM_STAGES]),
        .in_item      (stg_item[REM_STAGES]),
        .out_valid    (m_valid),
        .out_ready    (m_ready),
        .pixel_value  (m_pixel_value),
        .out_of_frame (m_out_of_frame)
    );

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Checks color_bar_test_pattern_pixel one pixel at a time against a
// behavioural predictor.
// Each accepted s_ beat is predicted from the register shadow (RGB32 bars,
// luma, chroma pair, dark band with the moving box, out-of-frame) and
// queued. Each m_ beat is compared with the oldest queued pixel. Directed
// beats cover the frame edges and size saturation. Random phases then run
// under several register settings, mostly with random gaps on both sides.
// ----------------------------------------------------------------------------
module tb_top;
    import cbtp_pkg::*;

    localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;

    localparam logic [31:0] ARGB_BARS [0:7] = '{
        32'hFFFF_FFFF, 32'hFFFF_FF00, 32'hFF00_FFFF, 32'hFF00_FF00,
        32'hFFFF_00FF, 32'hFFFF_0000, 32'hFF00_00FF, 32'hFF00_0000
    };
    localparam logic [7:0] LUMA_BARS [0:7] = '{235, 210, 170, 145, 106, 81, 41, 16};
    localparam logic [7:0] CB_BARS [0:7]   = '{128, 16, 166, 54, 202, 90, 240, 128};
    localparam logic [7:0] CR_BARS [0:7]   = '{128, 146, 16, 34, 222, 240, 110, 128};
    localparam logic [31:0] ARGB_BAND  = 32'hFF22_2222;
    localparam logic [31:0] ARGB_MARK  = 32'hFFFF_3333;
    localparam logic [7:0]  LUMA_BAND  = 8'd40;
    localparam logic [7:0]  LUMA_MARK  = 8'd220;
    localparam logic [7:0]  CHROMA_MID = 8'd128;
    localparam logic [7:0]  CR_MARK    = 8'd240;

    typedef struct {
        logic [PIX_W-1:0] value;
        logic             oof;
    } pixel_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [IDX_W-1:0]     cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 s_valid;
    logic                 s_ready;
    logic                 s_action;
    logic [FRAME_W-1:0]   s_frame_number;
    logic [COORD_W-1:0]   s_line;
    logic [COORD_W-1:0]   s_column;
    logic                 m_valid;
    logic                 m_ready;
    logic [PIX_W-1:0]     m_pixel_value;
    logic                 m_out_of_frame;

    logic [CFG_W-1:0]     cur_width;
    logic [CFG_W-1:0]     cur_height;
    logic                 cur_format;
    logic                 quiet;

    pixel_result_t        pixel_due_q[$];
    pixel_result_t        due_head;
    int                   err_count;
    int                   n_sent;
    int                   n_chroma;
    int                   n_oof;
    int                   n_checked;
    int                   n_settings;

    color_bar_test_pattern_pixel uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_frame_number (s_frame_number),
        .s_line         (s_line),
        .s_column       (s_column),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pixel_value  (m_pixel_value),
        .m_out_of_frame (m_out_of_frame)
    );

    always #4 aclk = ~aclk;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned lo,
                                              input int unsigned hi);
        if (v < lo) begin
            return lo;
        end else if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

    function automatic int unsigned bar_index(input int unsigned x, input int unsigned w);
        int unsigned b;
        b = x / (w / 8);
        return (b > 7) ? 7 : b;
    endfunction

    function automatic int unsigned box_left(input logic [31:0] frm, input int unsigned w);
        longint unsigned prod;
        prod = longint'(frm) * 6;
        return int'(prod % longint'(w - w / 16));
    endfunction

    function automatic bit box_hit(input int unsigned x, input int unsigned w,
                                   input logic [31:0] frm);
        int unsigned pos;
        pos = box_left(frm, w);
        return (x >= pos) && (x < pos + w / 16);
    endfunction

    function automatic pixel_result_t predict_pixel(input logic act, input logic [31:0] frm,
                                                    input logic [11:0] ln,
                                                    input logic [11:0] col);
        pixel_result_t r;
        int unsigned   w;
        int unsigned   h;
        int unsigned   top;
        int unsigned   x;
        int unsigned   b;
        w = clamp_dim(32'(cur_width), MIN_WIDTH, MAX_WIDTH);
        h = clamp_dim(32'(cur_height), MIN_HEIGHT, MAX_HEIGHT);
        top = (h * 3) / 4;
        r.value = '0;
        r.oof = 1'b0;
        if (cur_format == FMT_RGB32 || act == ACT_PIXEL) begin
            if (32'(ln) >= h || 32'(col) >= w) begin
                r.oof = 1'b1;
            end else if (32'(ln) < top) begin
                b = bar_index(32'(col), w);
                r.value = (cur_format == FMT_RGB32) ? ARGB_BARS[b] : 32'(LUMA_BARS[b]);
            end else if (cur_format == FMT_RGB32) begin
                r.value = box_hit(32'(col), w, frm) ? ARGB_MARK : ARGB_BAND;
            end else begin
                r.value = box_hit(32'(col), w, frm) ? 32'(LUMA_MARK) : 32'(LUMA_BAND);
            end
        end else begin
            x = 2 * int'(col);
            if (32'(ln) >= h / 2 || 32'(col) >= w / 2) begin
                r.oof = 1'b1;
            end else if (32'(ln) < top / 2) begin
                b = bar_index(x, w);
                r.value = {16'h0, CR_BARS[b], CB_BARS[b]};
            end else begin
                r.value = {16'h0, box_hit(x, w, frm) ? CR_MARK : CHROMA_MID, CHROMA_MID};
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        m_ready <= quiet || ($urandom_range(99) >= 10);
    end

    // entered and left at a falling edge; s_valid stays high after the beat
    task automatic send_pixel(input logic act, input logic [31:0] frm,
                              input logic [11:0] ln, input logic [11:0] col);
        pixel_result_t due;
        while (!quiet && $urandom_range(99) < 10) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        due = predict_pixel(act, frm, ln, col);
        s_valid        <= 1'b1;
        s_action       <= act;
        s_frame_number <= frm;
        s_line         <= ln;
        s_column       <= col;
        do @(posedge aclk); while (s_ready !== 1'b1);
        pixel_due_q.push_back(due);
        n_sent++;
        if (act == ACT_CHROMA && cur_format == FMT_NV12) n_chroma++;
        if (due.oof) n_oof++;
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pixel_due_q.size() != 0) @(negedge aclk);
    endtask

    task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        case (idx)
            REG_FRAME_WIDTH:  cur_width  = data;
            REG_FRAME_HEIGHT: cur_height = data;
            REG_PIXEL_FORMAT: cur_format = data[0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic apply_setting(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                                 input logic fmt);
        cfg_write(REG_FRAME_WIDTH, w);
        cfg_write(REG_FRAME_HEIGHT, h);
        cfg_write(REG_PIXEL_FORMAT, {12'h0, fmt});
        n_settings++;
    endtask

    // mostly in-frame, with a bias toward the lower band and the box
    task automatic random_pixels(input int count);
        int unsigned w;
        int unsigned h;
        int unsigned lim_l;
        int unsigned lim_c;
        int unsigned top;
        int unsigned x;
        int unsigned sel;
        logic        act;
        logic        chroma;
        logic [31:0] frm;
        logic [11:0] ln;
        logic [11:0] col;
        w = clamp_dim(32'(cur_width), MIN_WIDTH, MAX_WIDTH);
        h = clamp_dim(32'(cur_height), MIN_HEIGHT, MAX_HEIGHT);
        for (int i = 0; i < count; i++) begin
            act = 1'($urandom_range(1));
            frm = ($urandom_range(3) == 0) ? $urandom_range(200) : $urandom;
            chroma = (act == ACT_CHROMA) && (cur_format == FMT_NV12);
            lim_l = chroma ? h / 2 : h;
            lim_c = chroma ? w / 2 : w;
            top = chroma ? ((h * 3) / 4) / 2 : (h * 3) / 4;
            sel = $urandom_range(99);
            if (sel < 12) begin
                ln  = 12'($urandom);
                col = 12'($urandom);
            end else begin
                ln  = 12'($urandom_range(lim_l - 1));
                col = 12'($urandom_range(lim_c - 1));
                if (sel < 55 && top < lim_l) begin
                    ln = 12'(top + $urandom_range(lim_l - 1 - top));
                    x = box_left(frm, w) + $urandom_range(w / 16);
                    col = chroma ? 12'(x / 2) : 12'(x);
                end
            end
            send_pixel(act, frm, ln, col);
        end
    endtask

    // ------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (pixel_due_q.size() == 0) begin
                $error("result beat with nothing pending: pixel_value %h out_of_frame %b",
                       m_pixel_value, m_out_of_frame);
                err_count++;
            end else begin
                due_head = pixel_due_q.pop_front();
                n_checked++;
                if (m_pixel_value !== due_head.value) begin
                    $error("pixel_value expected %h actual %h", due_head.value, m_pixel_value);
                    err_count++;
                end
                if (m_out_of_frame !== due_head.oof) begin
                    $error("out_of_frame expected %b actual %b", due_head.oof, m_out_of_frame);
                    err_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_reset_geometry();
        // 640 x 480 NV12 after reset: bars end at line 360, box at 0 for frame 0
        send_pixel(ACT_PIXEL, 0, 0, 0);
        send_pixel(ACT_PIXEL, 0, 359, 639);
        send_pixel(ACT_PIXEL, 0, 360, 0);
        send_pixel(ACT_PIXEL, 0, 479, 40);
        send_pixel(ACT_PIXEL, 0, 480, 0);
        send_pixel(ACT_PIXEL, 0, 0, 640);
        send_pixel(ACT_PIXEL, 32'hFFFF_FFFF, 12'hFFF, 12'hFFF);
        send_pixel(ACT_CHROMA, 0, 0, 0);
        send_pixel(ACT_CHROMA, 0, 179, 319);
        send_pixel(ACT_CHROMA, 0, 180, 0);
        send_pixel(ACT_CHROMA, 0, 239, 20);
        send_pixel(ACT_CHROMA, 0, 240, 0);
        send_pixel(ACT_CHROMA, 0, 0, 320);
        send_pixel(ACT_PIXEL, 32'hFFFF_FFFF, 400, 12'd500);
        send_pixel(ACT_CHROMA, 32'hFFFF_FFFF, 200, 12'd250);
        drain_results();
    endtask

    task automatic test_edge_sizes();
        // narrow RGB frame: last column clamps to bar 7, chroma request ignored
        apply_setting(17, 5, FMT_RGB32);
        cfg_write(REG_SPARE, 13'h1FFF);
        send_pixel(ACT_PIXEL, 0, 0, 0);
        send_pixel(ACT_PIXEL, 0, 2, 16);
        send_pixel(ACT_PIXEL, 0, 3, 0);
        send_pixel(ACT_CHROMA, 0, 4, 16);
        send_pixel(ACT_PIXEL, 0, 5, 0);
        drain_results();
        // width saturates up to 16, odd height leaves two chroma rows
        apply_setting(0, 5, FMT_NV12);
        send_pixel(ACT_CHROMA, 3, 1, 0);
        send_pixel(ACT_CHROMA, 3, 2, 0);
        send_pixel(ACT_PIXEL, 3, 0, 15);
        drain_results();
        apply_setting(13'h1FFF, 13'h1FFF, FMT_NV12);
        send_pixel(ACT_PIXEL, 32'h8000_0001, 12'hFFF, 12'hFFF);
        send_pixel(ACT_CHROMA, 32'h8000_0001, 2047, 2047);
        drain_results();
        apply_setting(13'h1FFF, 0, FMT_RGB32);
        send_pixel(ACT_PIXEL, 7, 1, 4095);
        send_pixel(ACT_PIXEL, 7, 2, 0);
        drain_results();
    endtask

    task automatic test_extreme_settings();
        apply_setting(16, 2, FMT_RGB32);
        random_pixels(80);
        drain_results();
        apply_setting(16, 2, FMT_NV12);
        random_pixels(80);
        drain_results();
        apply_setting(4096, 4096, FMT_NV12);
        random_pixels(80);
        drain_results();
        apply_setting(4096, 4096, FMT_RGB32);
        random_pixels(80);
        drain_results();
        apply_setting(1, 1, FMT_NV12);
        random_pixels(80);
        drain_results();
        apply_setting(13'h1FFF, 3, FMT_NV12);
        random_pixels(80);
        drain_results();
    endtask

    task automatic test_random_settings();
        logic [CFG_W-1:0] w;
        logic [CFG_W-1:0] h;
        repeat (6) begin
            w = ($urandom_range(7) == 0) ? 13'($urandom_range(8191))
                                         : 13'($urandom_range(4096, 16));
            h = ($urandom_range(7) == 0) ? 13'($urandom_range(8191))
                                         : 13'($urandom_range(4096, 2));
            apply_setting(w, h, 1'($urandom_range(1)));
            random_pixels(80);
            drain_results();
        end
    endtask

    task automatic test_drain_pause();
        apply_setting(640, 480, FMT_NV12);
        random_pixels(40);
        drain_results();
        random_pixels(40);
        drain_results();
    endtask

    task automatic test_no_idle_stretch();
        apply_setting(1920, 1080, FMT_RGB32);
        quiet = 1'b1;
        random_pixels(60);
        drain_results();
        quiet = 1'b0;
    endtask

    // ------------------------------------------------------------------
    initial begin
        aresetn        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = REG_FRAME_WIDTH;
        cfg_data       = '0;
        s_valid        = 1'b0;
        s_action       = ACT_PIXEL;
        s_frame_number = '0;
        s_line         = '0;
        s_column       = '0;
        m_ready        = 1'b0;
        quiet          = 1'b0;
        cur_width      = RST_FRAME_WIDTH;
        cur_height     = RST_FRAME_HEIGHT;
        cur_format     = FMT_NV12;
        err_count      = 0;
        n_sent         = 0;
        n_chroma       = 0;
        n_oof          = 0;
        n_checked      = 0;
        n_settings     = 1;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_reset_geometry();
        test_edge_sizes();
        test_extreme_settings();
        test_random_settings();
        test_drain_pause();
        test_no_idle_stretch();

        drain_results();
        repeat (20) @(posedge aclk);
        $display("covered %0d pixels (%0d NV12 chroma, %0d out of frame), %0d checked",
                 n_sent, n_chroma, n_oof, n_checked);
        $display("over %0d register settings including saturated widths and heights",
                 n_settings);
        if (err_count == 0 && pixel_due_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("run limit reached, %0d pixels still pending", pixel_due_q.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
